// ===== src/tfs_pkg.sv =====
package tfs_pkg;

  // queue between the classifier and the sequencer
  localparam int unsigned TfsQueueDepth = 4;

  // register port
  localparam int unsigned PaddrWidth     = 3;
  localparam int unsigned PdataWidth     = 32;
  localparam logic        RegIdxCapacity = 1'b0;
  localparam logic [7:0]  CapacityReset  = 8'd64;

  // character codes
  localparam logic [7:0] CharNul    = 8'h00;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharAmp    = 8'h26;
  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharDel    = 8'h7F;
  localparam logic [7:0] ContMin    = 8'h80;
  localparam logic [7:0] Lead2Min   = 8'hC0;
  localparam logic [7:0] Lead3Min   = 8'hE0;
  localparam logic [7:0] Lead4Min   = 8'hF0;

  // entity table: lt, gt, amp, quot, #39
  localparam int unsigned NumEnt    = 5;
  localparam int unsigned EntMaxLen = 6;

  localparam logic [7:0] EntText [NumEnt][EntMaxLen] = '{
    '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
    '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
    '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},
    '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},
    '{8'h26, 8'h23, 8'h33, 8'h39, 8'h3B, 8'h00}
  };
  localparam logic [2:0] EntLen [NumEnt] = '{3'd4, 3'd4, 3'd5, 3'd6, 3'd5};
  localparam logic [7:0] EntChar [NumEnt] = '{8'h3C, 8'h3E, 8'h26, 8'h22, 8'h27};

  // byte classes
  typedef enum logic [2:0] {
    ClsPlain,
    ClsCtrl,
    ClsBslash,
    ClsAmp,
    ClsCont,
    ClsLead2,
    ClsLead3,
    ClsLead4
  } tfs_class_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } tfs_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] out_position;
    logic       is_final;
    logic [7:0] final_length;
  } tfs_out_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    tfs_class_e cls;
  } tfs_item_t;

  function automatic tfs_class_e tfs_classify(input logic [7:0] c);
    tfs_class_e cls;
    if (c < CharSpace || c == CharDel) begin
      cls = ClsCtrl;
    end else if (c == CharBslash) begin
      cls = ClsBslash;
    end else if (c == CharAmp) begin
      cls = ClsAmp;
    end else if (c >= Lead4Min) begin
      cls = ClsLead4;
    end else if (c >= Lead3Min) begin
      cls = ClsLead3;
    end else if (c >= Lead2Min) begin
      cls = ClsLead2;
    end else if (c >= ContMin) begin
      cls = ClsCont;
    end else begin
      cls = ClsPlain;
    end
    return cls;
  endfunction

endpackage

// ===== src/tfs_front.sv =====
module tfs_front #(
  parameter int unsigned Depth = tfs_pkg::TfsQueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tfs_pkg::tfs_in_t    in_data_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output tfs_pkg::tfs_item_t  q_item_o
);
  import tfs_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tfs_item_t          mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               push, pop;
  tfs_item_t          new_item;

  // classify the incoming byte once on entry
  always_comb begin
    new_item.data = in_data_i.in_byte;
    new_item.last = in_data_i.is_last;
    new_item.cls  = tfs_classify(in_data_i.in_byte);
  end

  assign in_ready_o = (cnt_q != CntW'(Depth));
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = mem_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    case ({push, pop})
      2'b10:   cnt_d = CntW'(cnt_q + 1'b1);
      2'b01:   cnt_d = CntW'(cnt_q - 1'b1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

// ===== src/tfs_back.sv =====
module tfs_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          capacity_i,
  input  logic                q_valid_i,
  output logic                q_ready_o,
  input  tfs_pkg::tfs_item_t  q_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tfs_pkg::tfs_out_t   out_data_o
);
  import tfs_pkg::*;

  // sequencer modes
  localparam logic [1:0] ModeIdle  = 2'd0;
  localparam logic [1:0] ModeUtf   = 2'd1;
  localparam logic [1:0] ModeRepl  = 2'd2;
  localparam logic [1:0] ModeFinal = 2'd3;

  logic [1:0]        mode_q, mode_d;
  logic [2:0]        idx_q, idx_d;
  logic [2:0]        n_q, n_d;
  logic              last_q, last_d;
  logic [7:0]        wc_q, wc_d;
  logic [7:0]        tl_q, tl_d;
  logic              stopped_q, stopped_d;
  logic [2:0]        fill_q, fill_d;
  logic [NumEnt-1:0] alive_q, alive_d;
  logic [2:0]        need_q, need_d;
  logic [2:0]        have_q, have_d;
  logic [7:0]        win_q [EntMaxLen];
  logic [7:0]        win_d [EntMaxLen];
  logic [7:0]        pend_q [4];
  logic [7:0]        pend_d [4];

  logic              out_valid_q;
  tfs_out_t          out_data_q;

  logic              step;
  logic              do_feed;
  logic [7:0]        f_byte;
  logic              f_last;
  tfs_class_e        f_cls;
  logic [2:0]        f_seq;
  logic              cap_full;
  logic              seq_nofit;
  logic              emit_en;
  logic [7:0]        emit_byte;
  logic              res_valid;
  tfs_out_t          res;
  logic [2:0]        n_ent;
  logic [NumEnt-1:0] alive_new;
  logic              full_hit;
  logic [7:0]        full_char;

  // the output register takes a new value when empty or being drained
  assign step        = !out_valid_q || out_ready_i;
  assign q_ready_o   = step && (mode_q == ModeIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // byte that goes through the plain path: queue head or a replayed window byte
  always_comb begin
    if (mode_q == ModeRepl) begin
      f_byte = win_q[idx_q];
      f_last = last_q && (idx_q == 3'(n_q - 3'd1));
      f_cls  = tfs_classify(win_q[idx_q]);
    end else begin
      f_byte = q_item_i.data;
      f_last = q_item_i.last;
      f_cls  = q_item_i.cls;
    end
    case (f_cls)
      ClsLead2: f_seq = 3'd2;
      ClsLead3: f_seq = 3'd3;
      ClsLead4: f_seq = 3'd4;
      default:  f_seq = 3'd1;
    endcase
    cap_full  = ({1'b0, wc_q} + 9'd1) >= {1'b0, capacity_i};
    seq_nofit = ({1'b0, wc_q} + 9'(f_seq) + 9'd1) > {1'b0, capacity_i};
  end

  // entity window match against the next byte
  always_comb begin
    n_ent     = 3'(fill_q + 3'd1);
    alive_new = '0;
    full_hit  = 1'b0;
    full_char = CharAmp;
    if (fill_q < 3'(EntMaxLen)) begin
      for (int e = NumEnt - 1; e >= 0; e--) begin
        alive_new[e] = alive_q[e] && (n_ent <= EntLen[e]) &&
                       (EntText[e][fill_q] == q_item_i.data);
        if (alive_new[e] && n_ent == EntLen[e]) begin
          full_hit  = 1'b1;
          full_char = EntChar[e];
        end
      end
    end
  end

  // sequencer: at most one result per step
  always_comb begin
    mode_d    = mode_q;
    idx_d     = idx_q;
    n_d       = n_q;
    last_d    = last_q;
    wc_d      = wc_q;
    tl_d      = tl_q;
    stopped_d = stopped_q;
    fill_d    = fill_q;
    alive_d   = alive_q;
    need_d    = need_q;
    have_d    = have_q;
    win_d     = win_q;
    pend_d    = pend_q;
    do_feed   = 1'b0;
    emit_en   = 1'b0;
    emit_byte = f_byte;
    res_valid = 1'b0;
    res       = '0;

    case (mode_q)
      ModeIdle: begin
        if (step && q_valid_i) begin
          last_d = q_item_i.last;
          if (stopped_q) begin
            // ignore until the last byte
          end else if (need_q != 3'd0) begin
            // collect a continuation byte of the open sequence
            pend_d[have_q[1:0]] = q_item_i.data;
            have_d              = 3'(have_q + 3'd1);
            if (3'(have_q + 3'd1) >= need_q) begin
              mode_d = ModeUtf;
              idx_d  = 3'd0;
            end else if (q_item_i.last) begin
              stopped_d = 1'b1;
            end
          end else if (fill_q != 3'd0) begin
            if (fill_q >= 3'(EntMaxLen)) begin
              fill_d = 3'd0;
            end else begin
              win_d[fill_q] = q_item_i.data;
              if (full_hit) begin
                fill_d    = 3'd0;
                emit_en   = 1'b1;
                emit_byte = full_char;
              end else if ((alive_new != '0) && !q_item_i.last) begin
                fill_d  = n_ent;
                alive_d = alive_new;
              end else begin
                // mismatch: keep the ampersand, replay the held bytes
                fill_d    = 3'd0;
                emit_en   = 1'b1;
                emit_byte = CharAmp;
                mode_d    = ModeRepl;
                idx_d     = 3'd1;
                n_d       = n_ent;
              end
            end
          end else begin
            do_feed = 1'b1;
          end
          if (q_item_i.last && mode_d == ModeIdle) begin
            mode_d = ModeFinal;
          end
        end
      end
      ModeUtf: begin
        if (step) begin
          emit_en   = 1'b1;
          emit_byte = pend_q[idx_q[1:0]];
          idx_d     = 3'(idx_q + 3'd1);
          if (3'(idx_q + 3'd1) == need_q) begin
            need_d = 3'd0;
            have_d = 3'd0;
            mode_d = last_q ? ModeFinal : ModeIdle;
          end
        end
      end
      ModeRepl: begin
        if (step) begin
          do_feed = 1'b1;
          idx_d   = 3'(idx_q + 3'd1);
          if (idx_q == 3'(n_q - 3'd1)) begin
            mode_d = last_q ? ModeFinal : ModeIdle;
          end
        end
      end
      ModeFinal: begin
        if (step) begin
          res_valid        = 1'b1;
          res.out_byte     = CharNul;
          res.out_position = tl_q;
          res.is_final     = 1'b1;
          res.final_length = tl_q;
          wc_d             = '0;
          tl_d             = '0;
          stopped_d        = 1'b0;
          fill_d           = 3'd0;
          need_d           = 3'd0;
          have_d           = 3'd0;
          mode_d           = ModeIdle;
        end
      end
      default: begin
        mode_d = ModeIdle;
      end
    endcase

    // plain byte path
    if (do_feed && !stopped_q) begin
      if (cap_full) begin
        stopped_d = 1'b1;
      end else if (f_cls == ClsBslash && !f_last) begin
        // dropped
      end else if (f_cls == ClsCtrl || f_cls == ClsCont) begin
        // dropped
      end else if (f_cls == ClsAmp && !f_last) begin
        win_d[0] = f_byte;
        fill_d   = 3'd1;
        alive_d  = '1;
      end else if (f_seq == 3'd1) begin
        emit_en   = 1'b1;
        emit_byte = f_byte;
      end else if (f_last || seq_nofit) begin
        stopped_d = 1'b1;
      end else begin
        pend_d[0] = f_byte;
        have_d    = 3'd1;
        need_d    = f_seq;
      end
    end

    // kept byte goes to the next destination slot
    if (emit_en) begin
      res_valid        = 1'b1;
      res.out_byte     = emit_byte;
      res.out_position = wc_q;
      res.is_final     = 1'b0;
      res.final_length = '0;
      wc_d             = 8'(wc_q + 8'd1);
      if (emit_byte != CharSpace) begin
        tl_d = 8'(wc_q + 8'd1);
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeIdle;
      idx_q       <= '0;
      n_q         <= '0;
      last_q      <= 1'b0;
      wc_q        <= '0;
      tl_q        <= '0;
      stopped_q   <= 1'b0;
      fill_q      <= '0;
      alive_q     <= '0;
      need_q      <= '0;
      have_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      idx_q     <= idx_d;
      n_q       <= n_d;
      last_q    <= last_d;
      wc_q      <= wc_d;
      tl_q      <= tl_d;
      stopped_q <= stopped_d;
      fill_q    <= fill_d;
      alive_q   <= alive_d;
      need_q    <= need_d;
      have_q    <= have_d;
      if (step) begin
        out_valid_q <= res_valid;
      end
    end
  end

  // payload: held bytes and the output register
  always_ff @(posedge clk_i) begin
    win_q  <= win_d;
    pend_q <= pend_d;
    if (step && res_valid) begin
      out_data_q <= res;
    end
  end

endmodule

// ===== src/text_field_sanitizer.sv =====
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_ready_o   in_data_i  (in_byte, is_last)
// out       output     out_valid_o / out_ready_i out_data_o (byte, position, final)
// register  input      psel/penable/pwrite       paddr, pwdata, prdata (capacity)
//
// the back sequencer handles a plain byte in idle mode, at most one result per cycle
// through its output register while the output is not stalled; a utf-8 sequence is
// collected and then written out byte by byte, an entity mismatch emits the ampersand
// and replays the held bytes, and the last byte of a field is followed by the final.
// the four-deep input queue accepts while the sequencer or output stalls, until full.
// reset is asynchronous, active low; capacity resets to 64.
module text_field_sanitizer #(
  parameter int unsigned QueueDepth = tfs_pkg::TfsQueueDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  tfs_pkg::tfs_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output tfs_pkg::tfs_out_t                 out_data_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tfs_pkg::PaddrWidth-1:0]    paddr,
  input  logic [tfs_pkg::PdataWidth-1:0]    pwdata,
  output logic [tfs_pkg::PdataWidth-1:0]    prdata,
  output logic                              pready
);
  import tfs_pkg::*;

  logic [7:0] cap_q;
  logic       reg_sel;
  logic       q_valid;
  logic       q_ready;
  tfs_item_t  q_item;

  // register port
  assign pready  = 1'b1;
  assign reg_sel = (paddr[PaddrWidth-1] == RegIdxCapacity);
  assign prdata  = reg_sel ? PdataWidth'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapacityReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      cap_q <= pwdata[7:0];
    end
  end

  // classifier and queue
  tfs_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_item_o   (q_item)
  );

  // sequencer and output register
  tfs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .capacity_i  (cap_q),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/sv/text_field_sanitizer_tb.sv =====
`timescale 1ns / 1ps

module text_field_sanitizer_tb;
  import tfs_pkg::*;

  localparam int unsigned ClkHalf        = 10;
  localparam int unsigned ResetCycles    = 7;
  localparam int unsigned PhaseBytes     = 36;
  localparam int unsigned NumPhases      = 10;
  localparam int unsigned SettleCycles   = 24;
  localparam int unsigned DrainCycles    = 40;
  localparam int unsigned CycleLimit     = 300000;
  localparam int unsigned MaxOutPerByte  = 8;
  localparam int unsigned MaxReported    = 10;
  localparam int unsigned NumDirRows     = 24;
  localparam logic [PaddrWidth-1:0] CapacityAddr = PaddrWidth'(4 * RegIdxCapacity);

  // decoded entities: lt, gt, amp, quot, #39
  localparam int unsigned HtmlNumEnt = 5;
  localparam logic [7:0] HtmlEntText [HtmlNumEnt][6] = '{
    '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
    '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
    '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},
    '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},
    '{8'h26, 8'h23, 8'h33, 8'h39, 8'h3B, 8'h00}
  };
  localparam int HtmlEntLen [HtmlNumEnt] = '{4, 4, 5, 6, 5};
  localparam logic [7:0] HtmlEntChar [HtmlNumEnt] = '{8'h3C, 8'h3E, 8'h26, 8'h22, 8'h27};

  typedef enum logic [1:0] {
    IdleNone,
    IdleSend,
    IdleRecv,
    IdleBoth
  } idle_mode_e;

  // one directed transaction, with an optional typed final length
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    logic [7:0] flen;
  } dir_row_t;

  localparam dir_row_t DirRows [NumDirRows] = '{
    '{8'h41, 1'b1, 1'b1, 8'd1},
    '{8'h5C, 1'b0, 1'b0, 8'd0},
    '{8'h00, 1'b0, 1'b0, 8'd0},
    '{8'h7F, 1'b0, 1'b0, 8'd0},
    '{8'h26, 1'b0, 1'b0, 8'd0},
    '{8'h67, 1'b0, 1'b0, 8'd0},
    '{8'h74, 1'b0, 1'b0, 8'd0},
    '{8'h3B, 1'b0, 1'b0, 8'd0},
    '{8'h26, 1'b0, 1'b0, 8'd0},
    '{8'h61, 1'b0, 1'b0, 8'd0},
    '{8'h6D, 1'b0, 1'b0, 8'd0},
    '{8'h70, 1'b0, 1'b0, 8'd0},
    '{8'h3B, 1'b0, 1'b0, 8'd0},
    '{8'h80, 1'b0, 1'b0, 8'd0},
    '{8'h26, 1'b0, 1'b0, 8'd0},
    '{8'h78, 1'b0, 1'b0, 8'd0},
    '{8'hFF, 1'b0, 1'b0, 8'd0},
    '{8'h20, 1'b1, 1'b0, 8'd0},
    '{8'h5C, 1'b1, 1'b1, 8'd1},
    '{8'h26, 1'b1, 1'b1, 8'd1},
    '{8'hC3, 1'b0, 1'b0, 8'd0},
    '{8'hA9, 1'b0, 1'b0, 8'd0},
    '{8'h20, 1'b1, 1'b1, 8'd2},
    '{8'h00, 1'b1, 1'b1, 8'd0}
  };

  localparam int PhaseCap [NumPhases] = '{64, 0, 1, 2, 5, 255, 9, 3, 17, 64};
  localparam idle_mode_e PhaseMode [NumPhases] = '{
    IdleNone, IdleSend, IdleRecv, IdleBoth, IdleNone,
    IdleSend, IdleRecv, IdleBoth, IdleBoth, IdleNone
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  tfs_in_t               in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  tfs_out_t              out_data_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PaddrWidth-1:0] paddr;
  logic [PdataWidth-1:0] pwdata;
  logic [PdataWidth-1:0] prdata;
  logic                  pready;

  // typed final length of the directed row on the input
  logic                  row_typed;
  logic [7:0]            row_flen;

  int                    send_pct;
  int                    recv_pct;
  int                    cycle_count;
  int                    mismatch_count;
  int                    bytes_taken;
  int                    fields_taken;
  int                    results_checked;

  // cleaner state as seen by the testbench
  logic [7:0]            cap_val;
  logic [7:0]            wr_count;
  logic [7:0]            trim_len;
  logic                  copy_halted;
  logic [7:0]            ent_win [6];
  int                    ent_fill;
  logic [7:0]            u8_buf [4];
  int                    u8_need;
  int                    u8_have;

  tfs_out_t              step_out [$];
  tfs_out_t              cleaned_q [$];
  tfs_out_t              want_out;
  logic [7:0]            field_q [$];

  text_field_sanitizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // clock
  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  task automatic note_mismatch(string what, logic [7:0] want, logic [7:0] got);
    mismatch_count++;
    if (mismatch_count <= MaxReported) begin
      $display("mismatch on %s: expected 0x%02h, got 0x%02h", what, want, got);
    end
  endtask

  // cleaner prediction
  function automatic void put_out(logic [7:0] b, logic [7:0] pos, logic fin, logic [7:0] flen);
    tfs_out_t r;
    if (step_out.size() >= MaxOutPerByte) begin
      return;
    end
    r.out_byte     = b;
    r.out_position = pos;
    r.is_final     = fin;
    r.final_length = flen;
    step_out.push_back(r);
  endfunction

  function automatic void emit_char(logic [7:0] b);
    put_out(b, wr_count, 1'b0, 8'h00);
    wr_count = wr_count + 8'd1;
    if (b != CharSpace) begin
      trim_len = wr_count;
    end
  endfunction

  function automatic void clear_field_state();
    wr_count    = 8'd0;
    trim_len    = 8'd0;
    copy_halted = 1'b0;
    ent_fill    = 0;
    u8_need     = 0;
    u8_have     = 0;
  endfunction

  // byte not claimed by an open entity window or utf-8 sequence
  function automatic void feed_plain(logic [7:0] c, logic last);
    int seq;
    seq = 1;
    if (copy_halted) begin
      return;
    end
    if (int'(wr_count) + 1 >= int'(cap_val)) begin
      copy_halted = 1'b1;
      return;
    end
    if (c == CharBslash && !last) begin
      return;
    end
    if (c < CharSpace || c == CharDel) begin
      return;
    end
    if (c == CharAmp && !last) begin
      ent_win[0] = c;
      ent_fill   = 1;
      return;
    end
    if (c >= Lead4Min) begin
      seq = 4;
    end else if (c >= Lead3Min) begin
      seq = 3;
    end else if (c >= Lead2Min) begin
      seq = 2;
    end else if (c >= ContMin) begin
      return;
    end
    if (seq == 1) begin
      emit_char(c);
      return;
    end
    if (last || int'(wr_count) + seq + 1 > int'(cap_val)) begin
      copy_halted = 1'b1;
      return;
    end
    u8_buf[0] = c;
    u8_have   = 1;
    u8_need   = seq;
  endfunction

  // byte added to the entity window, with replay on a mismatch
  function automatic void entity_step(logic [7:0] c, logic last);
    int n;
    logic prefix;
    logic hit;
    prefix = 1'b0;
    if (ent_fill >= 6) begin
      ent_fill = 0;
      return;
    end
    ent_win[ent_fill] = c;
    ent_fill++;
    n = ent_fill;
    for (int e = 0; e < HtmlNumEnt; e++) begin
      if (n > HtmlEntLen[e]) begin
        continue;
      end
      hit = 1'b1;
      for (int k = 0; k < n; k++) begin
        if (ent_win[k] != HtmlEntText[e][k]) begin
          hit = 1'b0;
        end
      end
      if (!hit) begin
        continue;
      end
      if (n == HtmlEntLen[e]) begin
        ent_fill = 0;
        emit_char(HtmlEntChar[e]);
        return;
      end
      prefix = 1'b1;
    end
    if (prefix && !last) begin
      return;
    end
    ent_fill = 0;
    emit_char(CharAmp);
    for (int k = 1; k + 1 < n; k++) begin
      feed_plain(ent_win[k], 1'b0);
    end
    feed_plain(ent_win[n-1], last);
  endfunction

  function automatic void sanitize_byte(logic [7:0] c, logic last);
    step_out.delete();
    if (!copy_halted) begin
      if (u8_need != 0) begin
        if (u8_have < 4) begin
          u8_buf[u8_have] = c;
        end
        u8_have++;
        if (u8_have >= u8_need) begin
          for (int k = 0; k < u8_need && k < 4; k++) begin
            emit_char(u8_buf[k]);
          end
          u8_need = 0;
          u8_have = 0;
        end else if (last) begin
          copy_halted = 1'b1;
        end
      end else if (ent_fill != 0) begin
        entity_step(c, last);
      end else begin
        feed_plain(c, last);
      end
    end
    if (last) begin
      put_out(CharNul, trim_len, 1'b1, trim_len);
      clear_field_state();
    end
  endfunction

  // random field: plain text, entities whole and broken, utf-8, noise
  function automatic void build_field();
    int target;
    int kind;
    int e;
    int n;
    field_q.delete();
    target = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    while (field_q.size() < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        field_q.push_back(($urandom_range(0, 3) == 0) ? CharSpace : 8'($urandom_range(8'h21, 8'h7E)));
      end else if (kind < 50) begin
        e = $urandom_range(0, HtmlNumEnt - 1);
        for (int k = 0; k < HtmlEntLen[e]; k++) begin
          field_q.push_back(HtmlEntText[e][k]);
        end
      end else if (kind < 58) begin
        e = $urandom_range(0, HtmlNumEnt - 1);
        n = $urandom_range(1, HtmlEntLen[e] - 1);
        for (int k = 0; k < n; k++) begin
          field_q.push_back(HtmlEntText[e][k]);
        end
        field_q.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 74) begin
        n = $urandom_range(2, 4);
        case (n)
          2: field_q.push_back(8'($urandom_range(8'hC0, 8'hDF)));
          3: field_q.push_back(8'($urandom_range(8'hE0, 8'hEF)));
          default: field_q.push_back(8'($urandom_range(8'hF0, 8'hFF)));
        endcase
        for (int k = 1; k < n; k++) begin
          field_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
      end else if (kind < 84) begin
        case ($urandom_range(0, 2))
          0: field_q.push_back(8'($urandom_range(0, 8'h1F)));
          1: field_q.push_back(CharDel);
          default: field_q.push_back(CharBslash);
        endcase
      end else if (kind < 90) begin
        field_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else begin
        field_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    // trailing spaces now and then
    if ($urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 3);
      for (int k = 0; k < n; k++) begin
        field_q.push_back(CharSpace);
      end
    end
  endfunction

  // one input transaction, entered and left at a falling edge
  task automatic send_byte(logic [7:0] data, logic last, logic typed, logic [7:0] flen);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        = 1'b1;
    in_data_i.in_byte = data;
    in_data_i.is_last = last;
    row_typed         = typed;
    row_flen          = flen;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // wait for the block to drain before touching the register
  task automatic settle();
    in_valid_i = 1'b0;
    while (cleaned_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic cap_write(logic [7:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = CapacityAddr;
    pwdata  = PdataWidth'(value);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    cap_val = value;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic cap_check(logic [7:0] want);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = CapacityAddr;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[7:0] !== want) begin
      note_mismatch("capacity readback", want, prdata[7:0]);
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // receiver back-pressure
  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(0, 99) < recv_pct) ? 1'b0 : 1'b1;
  end

  // prediction on input transactions, checking on output transactions
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sanitize_byte(in_data_i.in_byte, in_data_i.is_last);
        if (row_typed && in_data_i.is_last) begin
          step_out[step_out.size()-1].out_position = row_flen;
          step_out[step_out.size()-1].final_length = row_flen;
        end
        foreach (step_out[i]) begin
          cleaned_q.push_back(step_out[i]);
        end
        bytes_taken++;
        if (in_data_i.is_last) begin
          fields_taken++;
        end
      end
      if (out_valid_o && out_ready_i) begin
        if (cleaned_q.size() == 0) begin
          note_mismatch("unexpected result, out_byte", 8'h00, out_data_o.out_byte);
        end else begin
          want_out = cleaned_q.pop_front();
          results_checked++;
          if (out_data_o.out_byte !== want_out.out_byte) begin
            note_mismatch("out_byte", want_out.out_byte, out_data_o.out_byte);
          end
          if (out_data_o.out_position !== want_out.out_position) begin
            note_mismatch("out_position", want_out.out_position, out_data_o.out_position);
          end
          if (out_data_o.is_final !== want_out.is_final) begin
            note_mismatch("is_final", 8'(want_out.is_final), 8'(out_data_o.is_final));
          end
          if (out_data_o.final_length !== want_out.final_length) begin
            note_mismatch("final_length", want_out.final_length, out_data_o.final_length);
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("text_field_sanitizer verification failed");
      $finish;
    end
  end

  initial begin
    int sent;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_data_i       = '0;
    out_ready_i     = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    row_typed       = 1'b0;
    row_flen        = 8'd0;
    send_pct        = 0;
    recv_pct        = 0;
    cycle_count     = 0;
    mismatch_count  = 0;
    bytes_taken     = 0;
    fields_taken    = 0;
    results_checked = 0;
    cap_val         = CapacityReset;
    clear_field_state();

    // reset
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    cap_check(CapacityReset);

    // directed table at the reset capacity
    for (int k = 0; k < NumDirRows; k++) begin
      send_byte(DirRows[k].data, DirRows[k].last, DirRows[k].typed, DirRows[k].flen);
    end
    row_typed = 1'b0;

    // random fields over capacity settings and idling patterns
    for (int p = 0; p < NumPhases; p++) begin
      settle();
      cap_write(8'(PhaseCap[p]));
      cap_check(8'(PhaseCap[p]));
      case (PhaseMode[p])
        IdleSend: begin
          send_pct = 74;
          recv_pct = 0;
        end
        IdleRecv: begin
          send_pct = 0;
          recv_pct = 74;
        end
        IdleBoth: begin
          send_pct = 29;
          recv_pct = 29;
        end
        default: begin
          send_pct = 0;
          recv_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < PhaseBytes) begin
        build_field();
        for (int k = 0; k < field_q.size(); k++) begin
          send_byte(field_q[k], (k == field_q.size() - 1), 1'b0, 8'd0);
        end
        sent += field_q.size();
      end
    end

    // drain and close
    in_valid_i = 1'b0;
    recv_pct   = 0;
    while (cleaned_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (cleaned_q.size() != 0) begin
      mismatch_count += cleaned_q.size();
      $display("%0d expected results never arrived", cleaned_q.size());
    end
    $display("covered %0d bytes in %0d fields over %0d capacity settings",
             bytes_taken, fields_taken, NumPhases + 1);
    $display("%0d results checked, %0d mismatches", results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("text_field_sanitizer verification clean");
    end else begin
      $display("text_field_sanitizer verification failed");
    end
    $finish;
  end

endmodule
